>>> rtl/core/frp_pkg.sv
package frp_pkg;

  // Input beat: millisecond tick or received byte
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  // Result beat, one per received byte
  typedef struct packed {
    logic [2:0]  event_res;
    logic        timed_out;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic        stored;
    logic [15:0] msg_counter;
    logic [15:0] action_code;
    logic [15:0] payload_length;
  } out_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] max_gap_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_CNT1 = 3'd3,
    PH_CNT2 = 3'd4,
    PH_ACT1 = 3'd5,
    PH_ACT2 = 3'd6,
    PH_PAY  = 3'd7
  } phase_t;

  localparam logic        CMD_TICK = 1'b0;
  localparam logic        CMD_BYTE = 1'b1;

  localparam logic [2:0]  EV_IDLE    = 3'd0;
  localparam logic [2:0]  EV_PAYLOAD = 3'd1;
  localparam logic [2:0]  EV_DONE    = 3'd2;
  localparam logic [2:0]  EV_BAD_END = 3'd3;
  localparam logic [2:0]  EV_SHORT   = 3'd4;

  localparam logic [1:0]  CFG_START_BYTE = 2'd0;
  localparam logic [1:0]  CFG_END_BYTE   = 2'd1;
  localparam logic [1:0]  CFG_MAX_GAP    = 2'd2;

  localparam logic [15:0] HEADER_BYTES = 16'd8;
  localparam logic [15:0] HEADER_LAST  = 16'd7;
  localparam logic [15:0] GAP_MAX      = 16'hFFFF;

endpackage

>>> rtl/core/framed_request_parser_top.sv
// A byte beat passes the input register and then the result register
//   before it shows on out_valid. Throughput: one beat (byte or tick)
//   per cycle while in_stall is low; each beat passes a single parse step.
// Ticks produce no result beat. Reset (rst_n low, synchronous) returns the
//   parser to start-byte hunting, clears the gap counter and both stages, and
//   loads start_byte 123, end_byte 125 and max_gap_ms 100.
module framed_request_parser_top #(
  parameter int PAYLOAD_CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_valid,
  output logic          in_stall,
  input  frp_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output frp_pkg::out_t out_data,
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam logic [16:0] CAP = 17'(PAYLOAD_CAPACITY);

  // input stage
  logic          in_vld_r, in_vld_nxt;
  frp_pkg::in_t  in_data_r;
  // result stage
  logic          out_vld_r, out_vld_nxt;
  frp_pkg::out_t out_data_r;
  // configuration registers
  frp_pkg::cfg_t cfg_r;

  frp_pkg::out_t res;
  logic          drain_ok;
  logic          take;
  logic          in_take;

  // A held beat may leave the input stage when it is a tick (no result
  // needed) or when the result stage is empty or being drained this cycle.
  assign drain_ok = (in_data_r.cmd == frp_pkg::CMD_TICK) || !out_vld_r || !out_stall;
  assign take     = in_vld_r && drain_ok;
  assign in_stall = in_vld_r && !drain_ok;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take || (in_vld_r && !drain_ok);
  assign out_vld_nxt = (take && in_data_r.cmd == frp_pkg::CMD_BYTE) ||
                       (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Load a new input beat whenever the stage is free or draining.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Capture the result beat of a byte; hold it while stalled.
  always_ff @(posedge clk) begin
    if (take && in_data_r.cmd == frp_pkg::CMD_BYTE) begin
      out_data_r <= res;
    end
  end

  // Configuration: always ready; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= 8'd123;
      cfg_r.end_byte   <= 8'd125;
      cfg_r.max_gap_ms <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frp_pkg::CFG_START_BYTE: cfg_r.start_byte <= cfg_data[7:0];
        frp_pkg::CFG_END_BYTE:   cfg_r.end_byte   <= cfg_data[7:0];
        frp_pkg::CFG_MAX_GAP:    cfg_r.max_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state and the single parse step
  frp_core #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (take),
    .item (in_data_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A timeout always restarts hunting, so that byte cannot be payload or a close.
  a_tmo_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.timed_out |-> out_data_r.event_res == frp_pkg::EV_IDLE)
    else $error("timeout beat carries a non-idle event");

  // The stored flag tracks the capacity compare on payload beats.
  a_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.event_res == frp_pkg::EV_PAYLOAD |->
      out_data_r.stored == ({1'b0, out_data_r.payload_position} < CAP))
    else $error("stored flag disagrees with payload position");

  // Payload fields stay zero on other events.
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.event_res != frp_pkg::EV_PAYLOAD |->
      out_data_r.payload_position == 16'd0 && !out_data_r.stored &&
      out_data_r.payload_byte == 8'd0)
    else $error("payload fields set on a non-payload beat");

  // A tick leaving the input stage never creates a result beat.
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data_r.cmd == frp_pkg::CMD_TICK && !(out_vld_r && out_stall)
      |=> !out_vld_r)
    else $error("tick produced a result beat");

  // Event codes stay within the defined set.
  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_data_r.event_res <= frp_pkg::EV_SHORT)
    else $error("undefined event code");

endmodule

>>> rtl/core/frp_core.sv
module frp_core #(
  parameter int PAYLOAD_CAPACITY = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  frp_pkg::in_t  item,
  input  frp_pkg::cfg_t cfg,
  output frp_pkg::out_t res
);

  localparam logic [16:0] CAP = 17'(PAYLOAD_CAPACITY);

  frp_pkg::phase_t phase_r, phase_nxt, ph;
  logic [15:0] dlen_r, dlen_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] act_r, act_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic [15:0] rc_inc;
  logic [15:0] ppos;
  logic        tmo;

  always_comb begin
    phase_nxt = phase_r;
    dlen_nxt  = dlen_r;
    rcnt_nxt  = rcnt_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    gap_nxt   = gap_r;
    res       = '0;
    rc_inc    = rcnt_r + 16'd1;
    ppos      = rc_inc - frp_pkg::HEADER_BYTES;
    tmo       = (phase_r != frp_pkg::PH_HUNT) && (gap_r > cfg.max_gap_ms);
    ph        = tmo ? frp_pkg::PH_HUNT : phase_r;

    if (step && item.cmd == frp_pkg::CMD_TICK) begin
      // saturating gap count
      if (gap_r != frp_pkg::GAP_MAX) begin
        gap_nxt = gap_r + 16'd1;
      end
    end else if (step) begin
      gap_nxt       = '0;
      phase_nxt     = ph;
      res.timed_out = tmo;
      unique case (ph)
        frp_pkg::PH_HUNT: begin
          if (item.rx_byte == cfg.start_byte) begin
            phase_nxt = frp_pkg::PH_LEN1;
          end
        end
        frp_pkg::PH_LEN1: begin
          dlen_nxt  = {item.rx_byte, 8'd0};
          phase_nxt = frp_pkg::PH_LEN2;
        end
        frp_pkg::PH_LEN2: begin
          dlen_nxt = {dlen_r[15:8], item.rx_byte};
          if ({dlen_r[15:8], item.rx_byte} < frp_pkg::HEADER_BYTES) begin
            phase_nxt     = frp_pkg::PH_HUNT;
            res.event_res = frp_pkg::EV_SHORT;
          end else begin
            phase_nxt = frp_pkg::PH_CNT1;
          end
        end
        frp_pkg::PH_CNT1: begin
          cnt_nxt   = {item.rx_byte, 8'd0};
          phase_nxt = frp_pkg::PH_CNT2;
        end
        frp_pkg::PH_CNT2: begin
          cnt_nxt   = {cnt_r[15:8], item.rx_byte};
          phase_nxt = frp_pkg::PH_ACT1;
        end
        frp_pkg::PH_ACT1: begin
          act_nxt   = {item.rx_byte, 8'd0};
          phase_nxt = frp_pkg::PH_ACT2;
        end
        frp_pkg::PH_ACT2: begin
          act_nxt   = {act_r[15:8], item.rx_byte};
          rcnt_nxt  = frp_pkg::HEADER_LAST;
          phase_nxt = frp_pkg::PH_PAY;
        end
        frp_pkg::PH_PAY: begin
          rcnt_nxt = rc_inc;
          if (rc_inc < dlen_r) begin
            res.event_res        = frp_pkg::EV_PAYLOAD;
            res.payload_byte     = item.rx_byte;
            res.payload_position = ppos;
            res.stored           = ({1'b0, ppos} < CAP);
          end else if (item.rx_byte == cfg.end_byte) begin
            res.event_res      = frp_pkg::EV_DONE;
            res.msg_counter    = cnt_r;
            res.action_code    = act_r;
            res.payload_length = dlen_r - frp_pkg::HEADER_BYTES;
            phase_nxt          = frp_pkg::PH_HUNT;
          end else begin
            res.event_res = frp_pkg::EV_BAD_END;
            phase_nxt     = frp_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= frp_pkg::PH_HUNT;
      dlen_r  <= '0;
      rcnt_r  <= '0;
      cnt_r   <= '0;
      act_r   <= '0;
      gap_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      dlen_r  <= dlen_nxt;
      rcnt_r  <= rcnt_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      gap_r   <= gap_nxt;
    end
  end

endmodule

>>> sim/framed_request_parser_top_tb.sv
`timescale 1ns / 100ps

module framed_request_parser_top_tb;

  localparam int PAYLOAD_CAP = 256;
  // Generous: far above what the slowest idling and stalling phases need.
  localparam int CYCLE_LIMIT = 100_000;
  // Cycles to let pass after the last result before touching registers or ending.
  localparam int DRAIN_TAIL  = 6;
  // Long receiver hold-off used to back the pipeline up into the input.
  localparam int HOLD_CYCLES = 300;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam frp_pkg::out_t NO_REP = '0;

  // One row of the directed table: a beat, how many times to send it, and
  // optionally a hand-written expected report.
  typedef struct packed {
    frp_pkg::in_t  beat;
    logic [15:0]   reps;
    logic          typed;
    frp_pkg::out_t want;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  frp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall = 1'b0;
  frp_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [15:0]   cfg_data;

  framed_request_parser_top #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Deframer mirror: register copies and parse state.
  logic [7:0]       r_start;
  logic [7:0]       r_end;
  logic [15:0]      r_gap;
  frp_pkg::phase_t  p_phase;
  logic [15:0]      p_len;
  logic [15:0]      p_count;
  logic [15:0]      p_counter;
  logic [15:0]      p_action;
  logic [15:0]      p_gap;

  // Reports the parser owes us, oldest first.
  frp_pkg::out_t report_q [$];
  frp_pkg::out_t head_rep;

  int   mismatches    = 0;
  int   sent_beats    = 0;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_active   = 1'b0;
  event hold_go;

  // Directed rows, all under the reset register values (start 0x7B, end 0x7D,
  // max gap 100).
  dir_row_t directed_tab [27] = '{
    // hunting: any byte but the start byte is an idle report
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b1, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b1, NO_REP},
    // short declared length (7) drops back to hunting
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7B}, 16'd1, 1'b1, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h07}, 16'd1, 1'b1,
      frp_pkg::out_t'{frp_pkg::EV_SHORT, 1'b0, 8'h00, 16'h0000, 1'b0,
                      16'h0000, 16'h0000, 16'h0000}},
    // length exactly 8: the byte after the action is the end byte
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7B}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h08}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7D}, 16'd1, 1'b1,
      frp_pkg::out_t'{frp_pkg::EV_DONE, 1'b0, 8'h00, 16'h0000, 1'b0,
                      16'hFFFF, 16'h0000, 16'h0000}},
    // two payload bytes, then a wrong end byte
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7B}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h0A}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h01}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hAB}, 16'd1, 1'b1,
      frp_pkg::out_t'{frp_pkg::EV_PAYLOAD, 1'b0, 8'hAB, 16'h0000, 1'b1,
                      16'h0000, 16'h0000, 16'h0000}},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h55}, 16'd1, 1'b1,
      frp_pkg::out_t'{frp_pkg::EV_BAD_END, 1'b0, 8'h00, 16'h0000, 1'b0,
                      16'h0000, 16'h0000, 16'h0000}},
    // gap of 101 ticks inside a header restarts; the late byte opens a new frame
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7B}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'hFF}, 16'd1, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_TICK, 8'hA5}, 16'd101, 1'b0, NO_REP},
    '{frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h7B}, 16'd1, 1'b1,
      frp_pkg::out_t'{frp_pkg::EV_IDLE, 1'b1, 8'h00, 16'h0000, 1'b0,
                      16'h0000, 16'h0000, 16'h0000}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Kill a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Advance the deframer mirror by one accepted beat. Ticks only age the gap
  // counter; every byte yields exactly one report.
  function automatic void deframe_beat(input frp_pkg::in_t beat, output bit emits,
                                       output frp_pkg::out_t rep);
    logic [15:0] pos;
    rep   = '0;
    emits = 1'b0;
    if (beat.cmd == frp_pkg::CMD_TICK) begin
      if (p_gap != frp_pkg::GAP_MAX) p_gap++;
      return;
    end
    emits = 1'b1;
    // Gap is judged only inside a frame, and only when the next byte shows up.
    if (p_phase != frp_pkg::PH_HUNT && p_gap > r_gap) begin
      p_phase       = frp_pkg::PH_HUNT;
      rep.timed_out = 1'b1;
    end
    p_gap = '0;
    case (p_phase)
      frp_pkg::PH_HUNT: begin
        if (beat.rx_byte == r_start) p_phase = frp_pkg::PH_LEN1;
      end
      frp_pkg::PH_LEN1: begin
        p_len   = {beat.rx_byte, 8'h00};
        p_phase = frp_pkg::PH_LEN2;
      end
      frp_pkg::PH_LEN2: begin
        p_len[7:0] = beat.rx_byte;
        if (p_len < frp_pkg::HEADER_BYTES) begin
          p_phase       = frp_pkg::PH_HUNT;
          rep.event_res = frp_pkg::EV_SHORT;
        end else begin
          p_phase = frp_pkg::PH_CNT1;
        end
      end
      frp_pkg::PH_CNT1: begin
        p_counter = {beat.rx_byte, 8'h00};
        p_phase   = frp_pkg::PH_CNT2;
      end
      frp_pkg::PH_CNT2: begin
        p_counter[7:0] = beat.rx_byte;
        p_phase        = frp_pkg::PH_ACT1;
      end
      frp_pkg::PH_ACT1: begin
        p_action = {beat.rx_byte, 8'h00};
        p_phase  = frp_pkg::PH_ACT2;
      end
      frp_pkg::PH_ACT2: begin
        p_action[7:0] = beat.rx_byte;
        p_count       = frp_pkg::HEADER_LAST;
        p_phase       = frp_pkg::PH_PAY;
      end
      default: begin
        p_count++;
        if (p_count < p_len) begin
          pos                  = p_count - frp_pkg::HEADER_BYTES;
          rep.event_res        = frp_pkg::EV_PAYLOAD;
          rep.payload_byte     = beat.rx_byte;
          rep.payload_position = pos;
          rep.stored           = (pos < PAYLOAD_CAP);
        end else if (beat.rx_byte == r_end) begin
          rep.event_res      = frp_pkg::EV_DONE;
          rep.msg_counter    = p_counter;
          rep.action_code    = p_action;
          rep.payload_length = p_len - frp_pkg::HEADER_BYTES;
          p_phase            = frp_pkg::PH_HUNT;
        end else begin
          rep.event_res = frp_pkg::EV_BAD_END;
          p_phase       = frp_pkg::PH_HUNT;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat, holding it until taken, then log its expected report.
  // Idle the line first at the current sender rate.
  task automatic send_beat(input frp_pkg::in_t beat, input bit typed = 1'b0,
                           input frp_pkg::out_t want = '0);
    bit            emits;
    frp_pkg::out_t rep;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sent_beats++;
    deframe_beat(beat, emits, rep);
    if (emits) report_q.push_back(typed ? want : rep);
  endtask

  // Send a byte, now and then preceded by ticks; a few runs of ticks are just
  // long enough to trip the gap check.
  task automatic frame_byte(input logic [7:0] b);
    int r;
    int n;
    r = $urandom_range(99);
    n = 0;
    if (r >= 98 && r_gap < 500) n = r_gap + 1 + $urandom_range(2);
    else if (r >= 92) n = $urandom_range(1, 4);
    repeat (n) send_beat(frp_pkg::in_t'{frp_pkg::CMD_TICK, 8'($urandom)});
    send_beat(frp_pkg::in_t'{frp_pkg::CMD_BYTE, b});
  endtask

  task automatic send_frame(input int plen, input bit good_end);
    logic [15:0] len;
    logic [15:0] cnt;
    logic [15:0] act;
    len = 16'(plen + frp_pkg::HEADER_BYTES);
    cnt = 16'($urandom);
    act = 16'($urandom);
    frame_byte(r_start);
    frame_byte(len[15:8]);
    frame_byte(len[7:0]);
    frame_byte(cnt[15:8]);
    frame_byte(cnt[7:0]);
    frame_byte(act[15:8]);
    frame_byte(act[7:0]);
    for (int i = 0; i < plen; i++) frame_byte(8'($urandom));
    frame_byte(good_end ? r_end : 8'($urandom));
  endtask

  // Mostly well-formed frames with random content; the rest short lengths,
  // torn headers, stray bytes and loose ticks.
  task automatic random_traffic(input int n);
    int stop_at;
    int r;
    stop_at = sent_beats + n;
    while (sent_beats < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame($urandom_range(0, 12), $urandom_range(9) != 0);
      end else if (r < 78) begin
        frame_byte(r_start);
        frame_byte(8'h00);
        frame_byte(8'($urandom_range(0, 7)));
      end else if (r < 88) begin
        frame_byte(r_start);
        repeat ($urandom_range(1, 6)) frame_byte(8'($urandom));
      end else if (r < 94) begin
        frame_byte(8'($urandom));
      end else begin
        send_beat(frp_pkg::in_t'{frp_pkg::CMD_TICK, 8'($urandom)});
      end
    end
  endtask

  // Drop valid, wait out every owed report, then a few more cycles since ticks
  // may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Hold cfg_valid across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      frp_pkg::CFG_START_BYTE: r_start = data[7:0];
      frp_pkg::CFG_END_BYTE:   r_end   = data[7:0];
      frp_pkg::CFG_MAX_GAP:    r_gap   = data;
      default: ;
    endcase
  endtask

  // Load all three registers plus a write to the unmapped index, which must
  // be ignored. Upper data bits of the byte registers are junk on purpose.
  task automatic program_regs(input logic [7:0] sb, input logic [7:0] eb,
                              input logic [15:0] gap);
    write_reg(frp_pkg::CFG_START_BYTE, {8'($urandom), sb});
    write_reg(CFG_UNUSED, 16'($urandom));
    write_reg(frp_pkg::CFG_END_BYTE, {8'($urandom), eb});
    write_reg(frp_pkg::CFG_MAX_GAP, gap);
    cfg_valid <= 1'b0;
  endtask

  // Long receiver hold-off, timed here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Result side: check each taken beat against the oldest owed report, then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("result beat with no report owed: event_res 0x%0h", out_data.event_res);
        mismatches++;
      end else begin
        head_rep = report_q.pop_front();
        check_field("event_res", 16'(head_rep.event_res), 16'(out_data.event_res));
        check_field("timed_out", 16'(head_rep.timed_out), 16'(out_data.timed_out));
        check_field("payload_byte", 16'(head_rep.payload_byte),
                    16'(out_data.payload_byte));
        check_field("payload_position", head_rep.payload_position,
                    out_data.payload_position);
        check_field("stored", 16'(head_rep.stored), 16'(out_data.stored));
        check_field("msg_counter", head_rep.msg_counter, out_data.msg_counter);
        check_field("action_code", head_rep.action_code, out_data.action_code);
        check_field("payload_length", head_rep.payload_length, out_data.payload_length);
      end
    end
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= frp_pkg::CFG_START_BYTE;
    cfg_data  <= '0;

    // Mirror the reset state.
    r_start   = 8'd123;
    r_end     = 8'd125;
    r_gap     = 16'd100;
    p_phase   = frp_pkg::PH_HUNT;
    p_len     = '0;
    p_count   = '0;
    p_counter = '0;
    p_action  = '0;
    p_gap     = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side.
    foreach (directed_tab[i])
      repeat (directed_tab[i].reps)
        send_beat(directed_tab[i].beat, directed_tab[i].typed, directed_tab[i].want);
    drain();

    // Extremes: start 0x00, end 0xFF, zero gap (any tick inside a frame times
    // out). Push one frame whose payload may run past the payload capacity.
    program_regs(8'h00, 8'hFF, 16'd0);
    send_frame($urandom_range(PAYLOAD_CAP - 6, PAYLOAD_CAP + 14), 1'b1);
    random_traffic(80);
    drain();

    // Opposite extremes, sender idling most cycles.
    program_regs(8'hFF, 8'h00, 16'd3);
    send_idle_pct = 85;
    random_traffic(100);
    drain();

    // Random framing bytes, receiver stalling most cycles.
    program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)));
    send_idle_pct = 0;
    stall_pct     = 85;
    random_traffic(100);
    drain();

    // Back the block up: hold the receiver off while the sender streams flat
    // out, then light idling on both sides.
    program_regs(8'd123, 8'd125, 16'd100);
    stall_pct = 0;
    -> hold_go;
    random_traffic(60);
    send_idle_pct = 10;
    stall_pct     = 10;
    random_traffic(80);
    drain();

    // Max gap 65535: a long run of ticks inside a frame never times out.
    program_regs(8'd123, 8'd125, frp_pkg::GAP_MAX);
    send_idle_pct = 0;
    stall_pct     = 0;
    send_beat(frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'd123});
    send_beat(frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h00});
    repeat (40) send_beat(frp_pkg::in_t'{frp_pkg::CMD_TICK, 8'($urandom)});
    send_beat(frp_pkg::in_t'{frp_pkg::CMD_BYTE, 8'h05});
    drain();

    // One below the maximum, with some receiver stalls.
    program_regs(8'd123, 8'd125, frp_pkg::GAP_MAX - 16'd1);
    stall_pct = 30;
    random_traffic(40);
    drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
